// ===== rtl/bresenham_line_rasterizer_unit_assert.svh =====
// Assertion macros shared by the line rasterizer modules.
// No dependencies; define ASSERT_OFF to compile the assertions out.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define BLR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blr assertion failed");
`define BLR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("blr assertion failed");
`else
`define BLR_ASSERT(lbl, clk, rst_n, prop)
`define BLR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/blr_pkg.sv =====
// Package for the line rasterizer: payload structs, register indexes,
// controller state type and command/status structs. No dependencies.
package blr_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int COORD_W        = 6;
  localparam int CANVAS_W       = 7;
  localparam int RGB_W          = 24;
  localparam int CFG_IDX_W      = 2;
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 7'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [RGB_W-1:0]   line_rgb;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [RGB_W-1:0]   pixel_color;
    logic               last_pixel;
    logic               rejected;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DRAW,
    ST_REJECT
  } blr_state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic emit_pix;
    logic emit_rej;
  } blr_cmd_t;

  typedef struct packed {
    logic in_canvas;
    logic last;
    logic slot_free;
  } blr_sts_t;

endpackage

// ===== rtl/bresenham_line_rasterizer_unit.sv =====
// Bresenham line rasterizer, top level: controller plus datapath.
// Commands are loaded in ST_IDLE, checked in ST_CHECK, then drawn in ST_DRAW
// or rejected in ST_REJECT. A command of n = max(|dx|,|dy|)+1 pixels gets one
// pixel per cycle from the stepping loop, fewer when the output stalls; no new
// command is taken before its last item. rst_n is synchronous, active low; it
// sets both canvas registers to 64 and idles the controller.
module bresenham_line_rasterizer_unit #(
  parameter int MAX_WIDTH  = blr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  blr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output blr_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blr_pkg::CANVAS_W-1:0]  cfg_data
);
  import blr_pkg::*;

  blr_cmd_t cmd;
  blr_sts_t sts;

  assign cfg_ready = 1'b1;

  blr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  blr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/blr_ctrl.sv =====
// Controller state machine for the line rasterizer.
// Depends on blr_pkg and the assertion macro header.
`include "bresenham_line_rasterizer_unit_assert.svh"

module blr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  blr_pkg::blr_sts_t sts,
  output blr_pkg::blr_cmd_t cmd
);
  import blr_pkg::*;

  blr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.in_canvas ? ST_DRAW : ST_REJECT;
      end
      ST_DRAW: begin
        if (sts.slot_free && sts.last) state_nxt = ST_IDLE;
      end
      ST_REJECT: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.init = sts.in_canvas;
      end
      ST_DRAW: begin
        cmd.emit_pix = sts.slot_free;
      end
      ST_REJECT: begin
        cmd.emit_rej = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  `BLR_ASSERT(a_idle_no_emit, clk, rst_n, in_ready |-> !(cmd.emit_pix || cmd.emit_rej))
  `BLR_ASSERT(a_rej_to_idle, clk, rst_n, cmd.emit_rej |=> in_ready)
  `BLR_ASSERT(a_last_to_idle, clk, rst_n, (cmd.emit_pix && sts.last) |=> in_ready)

endmodule

// ===== rtl/blr_datapath.sv =====
// Datapath for the line rasterizer: canvas registers, endpoint check,
// Bresenham stepping and the output register. Depends on blr_pkg and the assertion macro header.
`include "bresenham_line_rasterizer_unit_assert.svh"

module blr_datapath #(
  parameter int MAX_WIDTH  = blr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blr_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  blr_pkg::in_item_t                in_data,
  input  logic                             cfg_valid,
  input  logic [blr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [blr_pkg::CANVAS_W-1:0]     cfg_data,
  input  blr_pkg::blr_cmd_t                cmd,
  output blr_pkg::blr_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output blr_pkg::out_item_t               out_data
);
  import blr_pkg::*;

  localparam logic [CANVAS_W-1:0] MAX_W = CANVAS_W'(MAX_WIDTH);
  localparam logic [CANVAS_W-1:0] MAX_H = CANVAS_W'(MAX_HEIGHT);

  logic [CANVAS_W-1:0] canvas_width_r, canvas_height_r;
  logic [COORD_W-1:0]  x0_r, y0_r, x1_r, y1_r;
  logic [RGB_W-1:0]    color_r;
  logic [COORD_W-1:0]  x_r, y_r, cnt_r;
  logic signed [8:0]   err_r, dmin2_r, dmaj2_r;
  logic                sx_neg_r, sy_neg_r, xmaj_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [CANVAS_W-1:0] wl, hl;
  logic [COORD_W:0]    dxs, dys, dx_negd, dy_negd;
  logic [COORD_W-1:0]  dx_abs, dy_abs, dmaj, dmin;
  logic signed [8:0]   dmin2, dmaj2, err_init, err_nxt;
  logic                err_pos, step_x, step_y;
  logic [COORD_W-1:0]  x_nxt, y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CANVAS_RESET;
      canvas_height_r <= CANVAS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_WIDTH)  canvas_width_r  <= cfg_data;
      if (cfg_index == CFG_IDX_HEIGHT) canvas_height_r <= cfg_data;
    end
  end

  assign wl = (canvas_width_r < MAX_W) ? canvas_width_r : MAX_W;
  assign hl = (canvas_height_r < MAX_H) ? canvas_height_r : MAX_H;

  assign sts.in_canvas = ({1'b0, x0_r} < wl) && ({1'b0, x1_r} < wl) &&
                         ({1'b0, y0_r} < hl) && ({1'b0, y1_r} < hl);
  assign sts.last      = (cnt_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;

  assign dxs     = {1'b0, x1_r} - {1'b0, x0_r};
  assign dys     = {1'b0, y1_r} - {1'b0, y0_r};
  assign dx_negd = '0 - dxs;
  assign dy_negd = '0 - dys;
  assign dx_abs  = dxs[COORD_W] ? dx_negd[COORD_W-1:0] : dxs[COORD_W-1:0];
  assign dy_abs  = dys[COORD_W] ? dy_negd[COORD_W-1:0] : dys[COORD_W-1:0];
  assign dmaj    = (dx_abs >= dy_abs) ? dx_abs : dy_abs;
  assign dmin    = (dx_abs >= dy_abs) ? dy_abs : dx_abs;
  assign dmin2    = $signed({2'b00, dmin, 1'b0});
  assign dmaj2    = $signed({2'b00, dmaj, 1'b0});
  assign err_init = dmin2 - $signed({3'b000, dmaj});

  assign err_pos = (err_r > 9'sd0);
  assign err_nxt = err_pos ? (err_r + dmin2_r - dmaj2_r) : (err_r + dmin2_r);
  assign step_x  = xmaj_r || err_pos;
  assign step_y  = !xmaj_r || err_pos;
  assign x_nxt   = sx_neg_r ? (x_r - 6'd1) : (x_r + 6'd1);
  assign y_nxt   = sy_neg_r ? (y_r - 6'd1) : (y_r + 6'd1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r    <= in_data.start_x;
      y0_r    <= in_data.start_y;
      x1_r    <= in_data.end_x;
      y1_r    <= in_data.end_y;
      color_r <= in_data.line_rgb;
    end
    if (cmd.init) begin
      x_r      <= x0_r;
      y_r      <= y0_r;
      cnt_r    <= dmaj;
      err_r    <= err_init;
      dmin2_r  <= dmin2;
      dmaj2_r  <= dmaj2;
      sx_neg_r <= dxs[COORD_W];
      sy_neg_r <= dys[COORD_W];
      xmaj_r   <= (dx_abs >= dy_abs);
    end else if (cmd.emit_pix) begin
      if (step_x) x_r <= x_nxt;
      if (step_y) y_r <= y_nxt;
      cnt_r <= cnt_r - 6'd1;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_pix || cmd.emit_rej) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pix) begin
      out_data_r.pixel_x     <= x_r;
      out_data_r.pixel_y     <= y_r;
      out_data_r.pixel_color <= color_r;
      out_data_r.last_pixel  <= (cnt_r == '0);
      out_data_r.rejected    <= 1'b0;
    end else if (cmd.emit_rej) begin
      out_data_r <= '{pixel_x: '0, pixel_y: '0, pixel_color: '0,
                      last_pixel: 1'b1, rejected: 1'b1};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BLR_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_ready) |-> !(cmd.emit_pix || cmd.emit_rej))
  `BLR_ASSERT(a_emit_shows, clk, rst_n, (cmd.emit_pix || cmd.emit_rej) |=> out_valid_r)
  `BLR_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid_r)

endmodule
